FILE: design/mfgr_pkg.sv
// ----------------------------------------------------------------------------
// mfgr_pkg
// Shared types, codes and helpers of the gray-rank color median filter.
// ----------------------------------------------------------------------------
package mfgr_pkg;

	localparam int PIXEL_W  = 24;
	localparam int GRAY_W   = 8;
	localparam int CFG_W    = 11;
	localparam int CFG_IDX_W = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd2;

	// Divide by three: floor(s * 683 / 2048) equals floor(s / 3) for s < 768.
	localparam logic [9:0] DIV3_MUL   = 10'd683;
	localparam int         DIV3_SHIFT = 11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_LAST,
		ST_SHIFT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                valid;
		logic [GRAY_W-1:0]   gray;
		logic [PIXEL_W-1:0]  color;
	} cell_t;

	typedef struct packed {
		logic clear;
		logic insert;
		logic shift;
	} chain_ctrl_t;

	function automatic logic [GRAY_W-1:0] gray_of(input logic [PIXEL_W-1:0] p);
		logic [9:0]  sum;
		logic [19:0] prod;
		sum  = 10'(p[7:0]) + 10'(p[15:8]) + 10'(p[23:16]);
		prod = 20'(sum) * 20'(DIV3_MUL);
		return prod[DIV3_SHIFT +: GRAY_W];
	endfunction

endpackage

FILE: design/mfgr_cell.sv
// ----------------------------------------------------------------------------
// mfgr_cell
// One slot of the sorting chain: stable insertion by gray, shift toward head.
// ----------------------------------------------------------------------------
module mfgr_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mfgr_pkg::chain_ctrl_t         ctrl,
	input  logic [mfgr_pkg::GRAY_W-1:0]   new_gray,
	input  logic [mfgr_pkg::PIXEL_W-1:0]  new_color,
	input  mfgr_pkg::cell_t               prev_cell,
	input  logic                          prev_gt,
	input  mfgr_pkg::cell_t               next_cell,
	output mfgr_pkg::cell_t               cur_cell,
	output logic                          gt
);

	logic                          valid_q;
	logic [mfgr_pkg::GRAY_W-1:0]   gray_q;
	logic [mfgr_pkg::PIXEL_W-1:0]  color_q;
	logic                          take_prev;
	logic                          take_new;

	assign cur_cell = '{valid: valid_q, gray: gray_q, color: color_q};

	// Equal grays go behind the stored ones, which keeps arrival order.
	assign gt = valid_q && (new_gray < gray_q);

	always_comb begin
		take_prev = 1'b0;
		take_new  = 1'b0;
		if (gt) begin
			take_prev = prev_gt;
			take_new  = !prev_gt;
		end else if (!valid_q) begin
			take_prev = prev_gt;
			take_new  = !prev_gt && prev_cell.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_cell.valid;
		end else if (ctrl.insert && (take_prev || take_new)) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			gray_q  <= next_cell.gray;
			color_q <= next_cell.color;
		end else if (ctrl.insert && take_prev) begin
			gray_q  <= prev_cell.gray;
			color_q <= prev_cell.color;
		end else if (ctrl.insert && take_new) begin
			gray_q  <= new_gray;
			color_q <= new_color;
		end
	end

endmodule

FILE: design/mfgr_line_buf.sv
// ----------------------------------------------------------------------------
// mfgr_line_buf
// Ring of recent image rows: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mfgr_line_buf #(
	parameter int DEPTH = 8192,
	parameter int AW    = 13
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [mfgr_pkg::PIXEL_W-1:0]  wr_data,
	input  logic [AW-1:0]                 rd_addr,
	output logic [mfgr_pkg::PIXEL_W-1:0]  rd_data_s1
);

	logic [mfgr_pkg::PIXEL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[rd_addr];
	end

endmodule

FILE: design/median_filter_gray_rank_color_core.sv
// ----------------------------------------------------------------------------
// median_filter_gray_rank_color_core
// Square-window median by gray rank over a streamed 24-bit color image.
// ----------------------------------------------------------------------------
// Sequence: an accepted item is checked against the window bounds; if an output
// is due, the window is read (one line buffer read per window pixel, n pixels,
// n being the clipped window size, 1 to 49 at radius 3) into the sorting chain,
// which then shifts out to the median before the result is offered.
// Throughput: one item at a time; an item that yields a result holds the block
// until its output is taken, and one that yields no result returns to idle.
// Reset: all counters cleared, registers 640 x 480, radius 1; no clearing pass.
module median_filter_gray_rank_color_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_RADIUS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [mfgr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mfgr_pkg::CFG_W-1:0]      cfg_data,
	// Pixel input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // blue_in [7:0], green_in [15:8], red_in [23:16]
	input  logic        s_tuser,   // drain
	// Filtered output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // blue_out [7:0], green_out [15:8], red_out [23:16]
	output logic        m_tlast,   // end_of_row
	output logic        m_tuser    // end_of_frame
);

	// Derived sizes. The ring holds 2R+2 rows so a full window plus the row
	// being written never collide.
	localparam int RING  = 2 * MAX_RADIUS + 2;
	localparam int RW    = $clog2(RING);
	localparam int COLW  = $clog2(MAX_WIDTH);
	localparam int ROWW  = $clog2(MAX_HEIGHT);
	localparam int RADW  = $clog2(MAX_RADIUS + 1);
	localparam int DEPTH = RING * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int SIDE  = 2 * MAX_RADIUS + 1;
	localparam int NCELL = SIDE * SIDE;
	localparam int CNTW  = $clog2(NCELL + 1);

	// Configuration registers.
	logic [mfgr_pkg::CFG_W-1:0] image_width_q;
	logic [mfgr_pkg::CFG_W-1:0] image_height_q;
	logic [1:0]                 radius_q;

	// Frame position.
	logic [COLW-1:0] in_col_q;
	logic [ROWW-1:0] in_row_q;
	logic [RW-1:0]   in_ring_q;
	logic [COLW-1:0] out_col_q;
	logic [ROWW-1:0] out_row_q;
	logic [RW-1:0]   out_ring_q;
	logic            complete_q;

	// Window walk.
	logic [COLW-1:0] x_q;
	logic [COLW-1:0] x_hi_q;
	logic [RW-1:0]   ring_q;
	logic [RW-1:0]   ring0_q;
	logic [RW-1:0]   yi_q;
	logic [RW-1:0]   y_last_q;
	logic            rd_valid_s1;

	// Rank pick.
	logic [CNTW-1:0]               count_q;
	logic [CNTW-1:0]               k_q;
	logic [mfgr_pkg::GRAY_W-1:0]   prev_gray_q;
	logic [mfgr_pkg::PIXEL_W-1:0]  first_q;
	logic [mfgr_pkg::PIXEL_W-1:0]  res_q;
	logic                          eor_q;
	logic                          eof_q;

	mfgr_pkg::state_t state_q, state_d;

	// Clamped settings: a zero size counts as one, oversize counts as the maximum.
	logic [COLW:0]   w_c;
	logic [ROWW:0]   h_c;
	logic [RADW-1:0] r_c;
	logic [COLW-1:0] w_m1;
	logic [ROWW-1:0] h_m1;

	always_comb begin
		if (image_width_q == '0) begin
			w_c = (COLW+1)'(1);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			w_c = (COLW+1)'(MAX_WIDTH);
		end else begin
			w_c = (COLW+1)'(image_width_q);
		end
		if (image_height_q == '0) begin
			h_c = (ROWW+1)'(1);
		end else if (32'(image_height_q) > 32'(MAX_HEIGHT)) begin
			h_c = (ROWW+1)'(MAX_HEIGHT);
		end else begin
			h_c = (ROWW+1)'(image_height_q);
		end
		if (32'(radius_q) > 32'(MAX_RADIUS)) begin
			r_c = RADW'(MAX_RADIUS);
		end else begin
			r_c = RADW'(radius_q);
		end
		w_m1 = COLW'(w_c - 1'b1);
		h_m1 = ROWW'(h_c - 1'b1);
	end

	// Window bounds of the next output and whether all of it has arrived.
	logic [COLW:0]   x_sum;
	logic [COLW-1:0] nx;
	logic [ROWW:0]   y_sum;
	logic [ROWW-1:0] ny;
	logic [COLW-1:0] dx;
	logic [ROWW-1:0] dy;
	logic [ROWW-1:0] y_lo;
	logic [RW:0]     ring_lo;
	logic            due;

	always_comb begin
		x_sum = (COLW+1)'(out_col_q) + (COLW+1)'(r_c);
		nx    = (x_sum > (COLW+1)'(w_m1)) ? w_m1 : COLW'(x_sum);
		y_sum = (ROWW+1)'(out_row_q) + (ROWW+1)'(r_c);
		ny    = (y_sum > (ROWW+1)'(h_m1)) ? h_m1 : ROWW'(y_sum);
		dx    = (out_col_q > COLW'(r_c)) ? COLW'(r_c) : out_col_q;
		dy    = (out_row_q > ROWW'(r_c)) ? ROWW'(r_c) : out_row_q;
		y_lo  = out_row_q - dy;
		if ((RW+1)'(out_ring_q) >= (RW+1)'(dy)) begin
			ring_lo = (RW+1)'(out_ring_q) - (RW+1)'(dy);
		end else begin
			ring_lo = (RW+1)'(out_ring_q) + (RW+1)'(RING) - (RW+1)'(dy);
		end
		due = complete_q || (in_row_q > ny) || ((in_row_q == ny) && (in_col_q > nx));
	end

	// Line buffer.
	logic                          accept;
	logic                          pix_wr;
	logic [AW-1:0]                 wr_addr;
	logic [AW-1:0]                 rd_addr;
	logic [mfgr_pkg::PIXEL_W-1:0]  rd_data_s1;

	assign accept  = s_tvalid && s_tready;
	assign pix_wr  = accept && !s_tuser && !complete_q;
	assign wr_addr = AW'(in_ring_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
	assign rd_addr = AW'(ring_q) * AW'(MAX_WIDTH) + AW'(x_q);

	mfgr_line_buf #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_line_buf (
		.clk        (clk),
		.wr_en      (pix_wr),
		.wr_addr    (wr_addr),
		.wr_data    (s_tdata),
		.rd_addr    (rd_addr),
		.rd_data_s1 (rd_data_s1)
	);

	// Sorting chain: every read window pixel is inserted by gray, ties behind
	// earlier ones, then the chain shifts toward cell 0 for the rank pick.
	mfgr_pkg::chain_ctrl_t         ctrl;
	logic [mfgr_pkg::GRAY_W-1:0]   new_gray;
	mfgr_pkg::cell_t               cells [NCELL];
	logic                          gts   [NCELL];
	mfgr_pkg::cell_t               head_src;
	mfgr_pkg::cell_t               tail_src;

	assign new_gray = mfgr_pkg::gray_of(rd_data_s1);
	assign head_src = '{valid: 1'b1, gray: '0, color: '0};
	assign tail_src = '{valid: 1'b0, gray: '0, color: '0};

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		mfgr_pkg::cell_t prev_c;
		mfgr_pkg::cell_t next_c;
		logic            prev_g;
		if (i == 0) begin : g_head
			assign prev_c = head_src;
			assign prev_g = 1'b0;
		end else begin : g_body
			assign prev_c = cells[i-1];
			assign prev_g = gts[i-1];
		end
		if (i == NCELL - 1) begin : g_tail
			assign next_c = tail_src;
		end else begin : g_mid
			assign next_c = cells[i+1];
		end
		mfgr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_gray  (new_gray),
			.new_color (rd_data_s1),
			.prev_cell (prev_c),
			.prev_gt   (prev_g),
			.next_cell (next_c),
			.cur_cell  (cells[i]),
			.gt        (gts[i])
		);
	end

	// Rank pick at the head: the first pixel of a gray run is remembered so
	// the chosen level answers with its earliest pixel in window order.
	logic [CNTW-1:0]               half;
	logic                          pick_now;
	logic [mfgr_pkg::PIXEL_W-1:0]  cand;
	logic                          walk_last;

	assign half     = count_q >> 1;
	assign pick_now = (state_q == mfgr_pkg::ST_SHIFT) && (k_q == half);
	assign cand     = ((k_q != '0) && (cells[0].gray == prev_gray_q)) ? first_q
	                                                                  : cells[0].color;
	assign walk_last = (x_q == x_hi_q) && (yi_q == y_last_q);

	// Control sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfgr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ctrl.clear  = 1'b0;
		ctrl.insert = rd_valid_s1;
		ctrl.shift  = 1'b0;
		s_tready    = 1'b0;
		m_tvalid    = 1'b0;
		case (state_q)
			mfgr_pkg::ST_IDLE: begin
				s_tready = !cfg_we;
				if (accept) begin
					state_d = mfgr_pkg::ST_CHECK;
				end
			end
			mfgr_pkg::ST_CHECK: begin
				if (due) begin
					ctrl.clear = 1'b1;
					state_d    = mfgr_pkg::ST_READ;
				end else begin
					state_d = mfgr_pkg::ST_IDLE;
				end
			end
			mfgr_pkg::ST_READ: begin
				if (walk_last) begin
					state_d = mfgr_pkg::ST_LAST;
				end
			end
			mfgr_pkg::ST_LAST: begin
				state_d = mfgr_pkg::ST_SHIFT;
			end
			mfgr_pkg::ST_SHIFT: begin
				if (pick_now) begin
					state_d = mfgr_pkg::ST_OUT;
				end else begin
					ctrl.shift = 1'b1;
				end
			end
			mfgr_pkg::ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = mfgr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mfgr_pkg::ST_IDLE;
			end
		endcase
	end

	// Configuration and frame position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= mfgr_pkg::CFG_W'(640);
			image_height_q <= mfgr_pkg::CFG_W'(480);
			radius_q       <= 2'd1;
			in_col_q       <= '0;
			in_row_q       <= '0;
			in_ring_q      <= '0;
			out_col_q      <= '0;
			out_row_q      <= '0;
			out_ring_q     <= '0;
			complete_q     <= 1'b0;
		end else if (cfg_we) begin
			// A write to a known register restarts the frame.
			case (cfg_index)
				mfgr_pkg::CFG_IMAGE_WIDTH,
				mfgr_pkg::CFG_IMAGE_HEIGHT,
				mfgr_pkg::CFG_RADIUS: begin
					in_col_q   <= '0;
					in_row_q   <= '0;
					in_ring_q  <= '0;
					out_col_q  <= '0;
					out_row_q  <= '0;
					out_ring_q <= '0;
					complete_q <= 1'b0;
				end
				default: begin
				end
			endcase
			case (cfg_index)
				mfgr_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				mfgr_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				mfgr_pkg::CFG_RADIUS:       radius_q       <= cfg_data[1:0];
				default: begin
				end
			endcase
		end else begin
			if (pix_wr) begin
				if (in_col_q == w_m1) begin
					in_col_q <= '0;
					if (in_row_q == h_m1) begin
						in_row_q   <= '0;
						in_ring_q  <= '0;
						complete_q <= 1'b1;
					end else begin
						in_row_q  <= in_row_q + 1'b1;
						in_ring_q <= (in_ring_q == RW'(RING - 1)) ? '0 : in_ring_q + 1'b1;
					end
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (m_tvalid && m_tready) begin
				if (eor_q) begin
					out_col_q <= '0;
					if (eof_q) begin
						out_row_q  <= '0;
						out_ring_q <= '0;
						complete_q <= 1'b0;
					end else begin
						out_row_q  <= out_row_q + 1'b1;
						out_ring_q <= (out_ring_q == RW'(RING - 1)) ? '0 : out_ring_q + 1'b1;
					end
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

	// Window walk and rank counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			count_q     <= '0;
			k_q         <= '0;
		end else begin
			rd_valid_s1 <= (state_q == mfgr_pkg::ST_READ);
			if (ctrl.clear) begin
				count_q <= '0;
				k_q     <= '0;
			end else begin
				if (rd_valid_s1) begin
					count_q <= count_q + 1'b1;
				end
				if (ctrl.shift) begin
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mfgr_pkg::ST_CHECK: begin
				x_q      <= out_col_q - dx;
				x_hi_q   <= nx;
				ring_q   <= RW'(ring_lo);
				ring0_q  <= RW'(ring_lo);
				yi_q     <= '0;
				y_last_q <= RW'(ny - y_lo);
				eor_q    <= (out_col_q == w_m1);
				eof_q    <= (out_col_q == w_m1) && (out_row_q == h_m1);
			end
			mfgr_pkg::ST_READ: begin
				// Column-major walk: rows of one column, then the next column.
				if (yi_q == y_last_q) begin
					yi_q   <= '0;
					ring_q <= ring0_q;
					x_q    <= x_q + 1'b1;
				end else begin
					yi_q   <= yi_q + 1'b1;
					ring_q <= (ring_q == RW'(RING - 1)) ? '0 : ring_q + 1'b1;
				end
			end
			mfgr_pkg::ST_SHIFT: begin
				prev_gray_q <= cells[0].gray;
				first_q     <= cand;
				if (pick_now) begin
					res_q <= cand;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tdata = res_q;
	assign m_tlast = eor_q;
	assign m_tuser = eof_q;

	// Checks.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_tvalid && s_tready))
		else $error("input taken while a result is pending");

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == mfgr_pkg::ST_CHECK))
		else $error("accepted item not followed by window check");

	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("end of frame without end of row");

	a_chain_fill: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(NCELL))
		else $error("sorting chain overfilled");

	a_pick_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mfgr_pkg::ST_SHIFT) |-> (k_q <= half))
		else $error("rank pick ran past the median");

endmodule

FILE: tb/sv/tb_median_filter_gray_rank_color_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_median_filter_gray_rank_color_core
// Self-checking bench for the gray-rank color median filter. Frames of small
// and extreme sizes are streamed through the block under random idling on
// both sides. Each output transfer is checked against an in-bench model of
// the window rank selection.
// ----------------------------------------------------------------------------
module tb_median_filter_gray_rank_color_core;

	localparam int  RING      = 8;
	localparam int  MAXW      = 1024;
	localparam int  MAXH      = 1024;
	localparam int  MAXR      = 3;
	localparam int  SETTLE    = 200;       // covers the longest item (49-pixel window)
	localparam longint LIMIT  = 3000000;

	typedef struct {
		logic [23:0] pix;
		logic        drain;
	} pixel_item_t;

	typedef struct {
		logic [23:0] pix;
		logic        eor;
		logic        eof;
	} filtered_px_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [mfgr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [mfgr_pkg::CFG_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic m_tlast;
	logic m_tuser;

	median_filter_gray_rank_color_core dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	pixel_item_t  pending[$];
	filtered_px_t expected_px[$];
	int errors = 0;
	int outputs_seen = 0;
	int frames_sent = 0;
	int items_sent = 0;
	longint cycles = 0;
	bit calm = 1'b0;   // when set, neither side idles

	// Window model: its own copy of the registers, line store and counters.
	logic [10:0] m_width, m_height;
	logic [1:0]  m_radius;
	logic [23:0] m_store [RING][MAXW];
	int m_in_col, m_in_row, m_out_col, m_out_row;
	bit m_complete;

	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (calm || p < 65) return 0;
		if (p < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic int gray_level(logic [23:0] p);
		return (int'(p[7:0]) + int'(p[15:8]) + int'(p[23:16])) / 3;
	endfunction

	function automatic void restart_model();
		m_in_col = 0; m_in_row = 0; m_out_col = 0; m_out_row = 0;
		m_complete = 1'b0;
	endfunction

	function automatic void apply_reg(logic [mfgr_pkg::CFG_IDX_W-1:0] idx,
			logic [mfgr_pkg::CFG_W-1:0] val);
		case (idx)
			mfgr_pkg::CFG_IMAGE_WIDTH: begin
				m_width = val;
			end
			mfgr_pkg::CFG_IMAGE_HEIGHT: begin
				m_height = val;
			end
			mfgr_pkg::CFG_RADIUS: begin
				m_radius = val[1:0];
			end
			default: begin
				return;
			end
		endcase
		restart_model();
	endfunction

	// Rank selection over the clipped window around the current output position.
	function automatic logic [23:0] rank_pick(int w, int h, int r);
		int cnt [256];
		logic [23:0] first [256];
		int x0, x1, y0, y1, half, acc, g;
		logic [23:0] p;
		foreach (cnt[i]) cnt[i] = 0;
		x0 = (m_out_col > r) ? m_out_col - r : 0;
		x1 = (m_out_col + r < w - 1) ? m_out_col + r : w - 1;
		y0 = (m_out_row > r) ? m_out_row - r : 0;
		y1 = (m_out_row + r < h - 1) ? m_out_row + r : h - 1;
		for (int x = x0; x <= x1; x++) begin
			for (int y = y0; y <= y1; y++) begin
				p = m_store[y % RING][x % MAXW];
				g = gray_level(p);
				if (cnt[g] == 0) first[g] = p;
				cnt[g]++;
			end
		end
		half = ((x1 - x0 + 1) * (y1 - y0 + 1)) / 2;
		acc = 0;
		for (int i = 0; i < 256; i++) begin
			acc += cnt[i];
			if (acc > half) return first[i];
		end
		return '0;
	endfunction

	// Advances the model by one input transfer, queueing the output it causes.
	function automatic void filter_step(pixel_item_t it);
		int w, h, r, arrived, need;
		filtered_px_t o;
		w = (m_width == 0) ? 1 : (m_width > MAXW ? MAXW : m_width);
		h = (m_height == 0) ? 1 : (m_height > MAXH ? MAXH : m_height);
		r = (m_radius > MAXR) ? MAXR : m_radius;
		if (!it.drain && !m_complete) begin
			m_store[m_in_row % RING][m_in_col % MAXW] = it.pix;
			m_in_col++;
			if (m_in_col >= w) begin
				m_in_col = 0;
				m_in_row++;
				if (m_in_row >= h) begin
					m_in_row = 0;
					m_complete = 1'b1;
				end
			end
		end
		arrived = m_complete ? w * h : m_in_row * w + m_in_col;
		need = ((m_out_row + r < h - 1) ? m_out_row + r : h - 1) * w +
			((m_out_col + r < w - 1) ? m_out_col + r : w - 1);
		if (arrived <= need) return;
		o.pix = rank_pick(w, h, r);
		o.eor = (m_out_col + 1 >= w);
		o.eof = o.eor && (m_out_row + 1 >= h);
		expected_px.push_back(o);
		if (o.eor) begin
			m_out_col = 0;
			m_out_row++;
			if (o.eof) begin
				m_out_row = 0;
				m_complete = 1'b0;
			end
		end else begin
			m_out_col++;
		end
	endfunction

	task automatic push_item(logic [23:0] pix, logic drain);
		pixel_item_t it;
		it.pix = pix;
		it.drain = drain;
		filter_step(it);
		pending.push_back(it);
		items_sent++;
	endtask

	function automatic logic [23:0] rand_pixel();
		case ($urandom_range(9))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			2: return {3{8'($urandom_range(255))}};
			default: return 24'($urandom);
		endcase
	endfunction

	// Waits until the block has nothing in flight, then lets it settle.
	task automatic wait_idle();
		while (pending.size() != 0 || s_tvalid || expected_px.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [mfgr_pkg::CFG_IDX_W-1:0] idx,
			logic [mfgr_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, val);
	endtask

	task automatic set_frame(logic [mfgr_pkg::CFG_W-1:0] w, logic [mfgr_pkg::CFG_W-1:0] h,
			logic [1:0] r);
		wait_idle();
		write_reg(mfgr_pkg::CFG_IMAGE_WIDTH, w);
		write_reg(mfgr_pkg::CFG_IMAGE_HEIGHT, h);
		write_reg(mfgr_pkg::CFG_RADIUS, mfgr_pkg::CFG_W'(r));
	endtask

	// Drains outputs owed after the last pixel; now and then a pixel is sent
	// instead, which the block must drop. One extra drain finds nothing owed.
	task automatic finish_frame();
		while (m_complete) begin
			if ($urandom_range(5) == 0) push_item(rand_pixel(), 1'b0);
			else push_item(24'($urandom), 1'b1);
		end
		push_item(24'($urandom), 1'b1);
		frames_sent++;
	endtask

	task automatic send_frame(int n);
		for (int i = 0; i < n; i++) push_item(rand_pixel(), 1'b0);
		finish_frame();
	endtask

	task automatic report(string what);
		$display("mismatch at output %0d: %s", outputs_seen, what);
		errors++;
	endtask

	// Driver: presents queued items with random gaps between transfers.
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending.size() > 0) begin
				pixel_item_t it;
				it = pending.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= it.pix;
				s_tuser <= it.drain;
				in_gap <= gap_len();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver stalls: ready is dropped for random stretches.
	int out_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(3) == 0) out_gap <= gap_len();
			end
		end
	end

	// Monitor: every output transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_px.size() == 0) begin
				report("output transfer with nothing expected");
			end else begin
				filtered_px_t e;
				e = expected_px.pop_front();
				if (m_tdata !== e.pix)
					report($sformatf("color %h, expected %h", m_tdata, e.pix));
				if (m_tlast !== e.eor)
					report($sformatf("end_of_row %b, expected %b", m_tlast, e.eor));
				if (m_tuser !== e.eof)
					report($sformatf("end_of_frame %b, expected %b", m_tuser, e.eof));
			end
			outputs_seen++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout with %0d outputs still expected", expected_px.size());
			$display("tb_median_filter_gray_rank_color_core failed");
			$finish;
		end
	end

	initial begin
		int w, h;
		m_width = 11'd640;
		m_height = 11'd480;
		m_radius = 2'd1;
		restart_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: a 3 x 3 image of color extremes, primaries and equal grays.
		set_frame(3, 3, 1);
		push_item(24'h000000, 1'b0);
		push_item(24'hFFFFFF, 1'b0);
		push_item(24'h0000FF, 1'b0);
		push_item(24'h00FF00, 1'b0);
		push_item(24'hFF0000, 1'b0);
		push_item(24'h555555, 1'b0);
		push_item(24'h5555FF, 1'b0);
		push_item(24'h010203, 1'b0);
		push_item(24'hFEFDFC, 1'b0);
		finish_frame();

		// Radius zero passes pixels through; sizes of zero count as one.
		set_frame(4, 2, 0);
		send_frame(8);
		set_frame(0, 0, 3);
		send_frame(1);

		// Index outside the register list leaves everything untouched.
		wait_idle();
		write_reg(2'd3, 11'h7FF);
		send_frame(1);

		// A register write in the middle of a frame restarts it.
		set_frame(5, 4, 2);
		for (int i = 0; i < 9; i++) push_item(rand_pixel(), 1'b0);
		set_frame(5, 4, 2);
		send_frame(20);

		// Size extremes: oversized width and height clamp to the maxima. Only
		// the start of each frame is sent; the next register write restarts it.
		calm = 1'b1;
		set_frame(11'h7FF, 1, 3);
		for (int i = 0; i < 100; i++) push_item(rand_pixel(), 1'b0);
		set_frame(1, 11'h7FF, 3);
		for (int i = 0; i < 100; i++) push_item(rand_pixel(), 1'b0);
		calm = 1'b0;

		// Random frames, mostly small, with every radius.
		while (items_sent < 950) begin
			w = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(10, 1);
			h = $urandom_range(8, 1);
			calm = ($urandom_range(4) == 0);
			set_frame(mfgr_pkg::CFG_W'(w), mfgr_pkg::CFG_W'(h), 2'($urandom_range(3)));
			send_frame(w * h);
		end

		wait_idle();
		$display("%0d frames, %0d items, %0d outputs checked, radius 0..3",
			frames_sent, items_sent, outputs_seen);
		$display("sizes up to 40 x 8, zero sizes and clamped oversize frames");
		if (errors == 0) begin
			$display("tb_median_filter_gray_rank_color_core passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("tb_median_filter_gray_rank_color_core failed");
		end
		$finish;
	end

endmodule
